[design/mbps_pkg.sv]
// Shared types and constants for the masked byte pattern scanner.
// Used by mbps_cell and masked_byte_pattern_scanner; depends on nothing.
package mbps_pkg;

  localparam int PATTERN_MAX = 128;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int FILL_W      = $clog2(PATTERN_MAX + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  localparam int   CFG_IDX_W          = 1;
  localparam int   CFG_DATA_W         = 8;
  localparam logic REG_PATTERN_LENGTH = 1'b0;
  localparam logic REG_RESULT_OFFSET  = 1'b1;

  typedef struct packed {
    logic       care;
    logic [7:0] pattern_byte;
  } entry_t;

  typedef struct packed {
    logic        operation;
    logic [6:0]  pattern_index;
    logic [7:0]  pattern_byte;
    logic        care;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic        region_first;
    logic        region_last;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_address;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

endpackage

[design/mbps_cell.sv]
// One position of the scanner chain: a pattern entry, one window byte and the
// partial-match flag for the pattern prefix ending here. Uses mbps_pkg.
module mbps_cell import mbps_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     load_entry,
  input  logic [7:0] byte_in,
  input  logic [7:0] cmp_byte,
  input  logic       flag_in,
  output logic [7:0] byte_out,
  output logic       flag_out,
  output logic       flag_next
);

  entry_t     entry;
  logic [7:0] win;
  logic       flag;

  // prefix up to here matches if the shorter prefix matched one byte ago
  assign flag_next = flag_in & (~entry.care | (entry.pattern_byte == cmp_byte));
  assign byte_out  = win;
  assign flag_out  = flag;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= load_entry;
    end
    if (ctrl.step) begin
      win  <= byte_in;
      flag <= flag_next;
    end
  end

endmodule

[design/masked_byte_pattern_scanner.sv]
// Masked byte pattern scanner, top level: chain of PATTERN_MAX cells, config, result register.
// A result is registered at the edge that accepts the deciding byte.
// Throughput: one item per cycle while not stalled; a pattern load in an open region
// replays the window through the cell chain, stalling input until it has rotated in full.
// Reset (rst, synchronous): pattern_length 1, result_offset 0, window empty, no result pending.
// Depends on mbps_pkg and mbps_cell.
module masked_byte_pattern_scanner import mbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0]        pattern_length;
  logic [7:0]        result_offset;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              reported;
  logic              replaying;
  logic [IDX_W-1:0]  replay_cnt;

  logic             accept;
  logic             is_load;
  logic             is_scan;
  logic             load_ok;
  logic             reported_eff;
  logic [FILL_W-1:0] fill_eff;
  logic             scan_take;
  logic             step;
  logic             hit;
  logic             region_end;
  logic [IDX_W-1:0] len_m1;
  logic [8:0]       len9;
  logic [31:0]      addr_adjust;
  logic [7:0]       feed_byte;
  entry_t           load_entry;

  cell_ctrl_t          ctrl      [PATTERN_MAX];
  logic [7:0]          win       [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] flag;
  logic [PATTERN_MAX-1:0] flag_next;

  assign item_stall = replaying | (result_valid & result_stall);
  assign accept     = item_valid & ~item_stall;
  assign is_load    = accept & (item.operation == OP_LOAD);
  assign is_scan    = accept & (item.operation == OP_SCAN);
  assign load_ok    = {2'b00, item.pattern_index} < 9'(PATTERN_MAX);

  assign reported_eff = item.region_first ? 1'b0 : reported;
  assign fill_eff     = item.region_first ? '0 : fill;
  assign fill_next    = (fill_eff == FILL_W'(PATTERN_MAX)) ? fill_eff
                                                           : fill_eff + FILL_W'(1);
  assign scan_take    = is_scan & ~reported_eff;
  assign step         = scan_take | replaying;

  // replay feeds the oldest byte back in, so the window rotates once in full
  assign feed_byte  = replaying ? win[PATTERN_MAX-1] : item.data_byte;
  assign load_entry = '{care: item.care, pattern_byte: item.pattern_byte};

  // effective pattern length minus one
  assign len9 = {1'b0, pattern_length};
  always_comb begin
    if (pattern_length == 8'd0) begin
      len_m1 = '0;
    end else if (len9 > 9'(PATTERN_MAX)) begin
      len_m1 = IDX_W'(PATTERN_MAX - 1);
    end else begin
      len_m1 = IDX_W'(len9 - 9'd1);
    end
  end

  assign addr_adjust = 32'(result_offset) - 32'(len_m1);
  assign hit         = scan_take & (fill_next > FILL_W'(len_m1)) & flag_next[len_m1];
  assign region_end  = scan_take & item.region_last & ~hit;

  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_cell
    assign ctrl[p].load = is_load & load_ok & ({1'b0, item.pattern_index} == 8'(p));
    assign ctrl[p].step = step;

    if (p == 0) begin : g_head
      mbps_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl[p]),
        .load_entry (load_entry),
        .byte_in    (feed_byte),
        .cmp_byte   (feed_byte),
        .flag_in    (1'b1),
        .byte_out   (win[p]),
        .flag_out   (flag[p]),
        .flag_next  (flag_next[p])
      );
    end else begin : g_body
      mbps_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl[p]),
        .load_entry (load_entry),
        .byte_in    (win[p-1]),
        .cmp_byte   (feed_byte),
        .flag_in    (flag[p-1]),
        .byte_out   (win[p]),
        .flag_out   (flag[p]),
        .flag_next  (flag_next[p])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= 8'd1;
      result_offset  <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length <= cfg_data;
        REG_RESULT_OFFSET:  result_offset  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      reported   <= 1'b0;
      replaying  <= 1'b0;
      replay_cnt <= '0;
    end else begin
      if (is_scan) begin
        reported <= reported_eff | hit | region_end;
      end
      if (scan_take) begin
        fill <= fill_next;
      end
      // a new entry invalidates the prefix flags of an open region: rebuild them
      if (is_load & load_ok & (fill != '0) & ~reported) begin
        replaying  <= 1'b1;
        replay_cnt <= '0;
      end else if (replaying) begin
        replay_cnt <= replay_cnt + IDX_W'(1);
        if (replay_cnt == IDX_W'(PATTERN_MAX - 1)) begin
          replaying <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (hit | region_end) begin
      result_valid <= 1'b1;
    end else if (~result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit | region_end) begin
      result.found         <= hit;
      result.match_address <= hit ? item.byte_address + addr_adjust : 32'd0;
    end
  end

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |-> (result.match_address == 32'd0))
    else $error("not-found transaction carries a nonzero address");

  a_replay_length: assert property (@(posedge clk) disable iff (rst)
    $rose(replaying) |-> ##(PATTERN_MAX - 1)
      (replaying && (replay_cnt == IDX_W'(PATTERN_MAX - 1))))
    else $error("window replay did not run its full length");

  a_reported_holds: assert property (@(posedge clk) disable iff (rst)
    (reported && !(is_scan && item.region_first)) |=> reported)
    else $error("finished region reopened without a region start");

  a_result_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(is_scan))
    else $error("result transaction not caused by a scan");

endmodule
